// ----- hdl/tksit_pkg.sv -----
// package for the top-k sorted insert table
// entry type, depth default and name cleanup function; no dependencies
package tksit_pkg;

  localparam int TK_DEPTH = 16;

  localparam int SCORE_W = 31;
  localparam int LEVEL_W = 8;
  localparam int TIME_W  = 32;
  localparam int NAME_W  = 64;
  localparam int INDEX_W = 4;
  localparam int RANK_W  = 4;
  localparam int COUNT_W = 5;

  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 216;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_READ   = 1'b1
  } mode_t;

  typedef struct packed {
    logic [NAME_W-1:0]  name_high;
    logic [NAME_W-1:0]  name_low;
    logic [TIME_W-1:0]  timestamp;
    logic [LEVEL_W-1:0] level;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   ins_en;
    entry_t cand;
  } cell_cmd_t;

  // zero every byte after the first zero byte
  function automatic logic [2*NAME_W-1:0] clean_name(input logic [2*NAME_W-1:0] name);
    logic [2*NAME_W-1:0] res;
    logic                ended;
    res   = name;
    ended = 1'b0;
    for (int b = 0; b < 16; b++) begin
      if (ended) begin
        res[b*8 +: 8] = 8'h00;
      end else if (name[b*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ----- hdl/tksit_cell.sv -----
// one slot of the sorted table: holds an entry, compares it with the new score
// and takes the new entry or its upper neighbor's entry on insert; uses tksit_pkg
module tksit_cell (
  input  logic                 clk,
  input  tksit_pkg::cell_cmd_t cmd,
  input  logic                 valid_i,
  input  logic                 prev_gt_i,
  input  tksit_pkg::entry_t    prev_entry_i,
  output tksit_pkg::entry_t    entry_o,
  output logic                 gt_o
);
  import tksit_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign gt_o    = valid_i && (entry_r.score > cmd.cand.score);
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_en && !gt_o) begin
      entry_nxt = prev_gt_i ? cmd.cand : prev_entry_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- hdl/top_k_sorted_insert_table_top.sv -----
// top level of the top-k sorted insert table: a row of tksit_cell slots,
// fill count and registered result; uses tksit_pkg and tksit_cell
//
// channel | dir | handshake          | content
// in_     | in  | tvalid/tready      | tuser mode, tdata insert entry or read index
// out_    | out | tvalid/tready      | tdata result item
//
// one item per cycle while in_tready is high: all cells compare in parallel and shift in the same edge
// the result is registered and shows in the cycle after the item is taken
// in_tready stays high while the result register is empty or being drained
// reset clears the fill count and the result valid; slot contents are kept
module top_k_sorted_insert_table_top #(
  parameter int DEPTH = tksit_pkg::TK_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // score, level, timestamp, name_low, name_high, read_index
  input  logic [tksit_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // accepted, rank, entry_count, entry_valid, entry_score, entry_level,
  // entry_timestamp, entry_name_low, entry_name_high
  output logic [tksit_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tksit_pkg::*;

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int RdSpan = (DEPTH < 16) ? DEPTH : 16;

  logic                  in_acc;
  mode_t                 mode;
  logic [SCORE_W-1:0]    in_score;
  logic [LEVEL_W-1:0]    in_level;
  logic [TIME_W-1:0]     in_time;
  logic [2*NAME_W-1:0]   in_name;
  logic [2*NAME_W-1:0]   clean;
  logic [INDEX_W-1:0]    read_index;

  cell_cmd_t             cmd;
  entry_t                entry_w [DEPTH];
  logic [DEPTH-1:0]      gt_w;
  logic [DEPTH-1:0]      prev_gt_w;
  logic [DEPTH-1:0]      valid_w;
  logic [DEPTH-1:0]      place_w;

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  ins_ok;
  logic [RANK_W-1:0]     rank_c;
  entry_t                rd_entry;
  logic                  rd_valid;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign mode       = mode_t'(in_tuser);
  assign in_score   = in_tdata[30:0];
  assign in_level   = in_tdata[38:31];
  assign in_time    = in_tdata[70:39];
  assign in_name    = in_tdata[198:71];
  assign read_index = in_tdata[202:199];
  assign clean      = clean_name(in_name);

  assign cmd.ins_en          = in_acc && (mode == MODE_INSERT);
  assign cmd.cand.score      = in_score;
  assign cmd.cand.level      = in_level;
  assign cmd.cand.timestamp  = in_time;
  assign cmd.cand.name_low   = clean[NAME_W-1:0];
  assign cmd.cand.name_high  = clean[2*NAME_W-1:NAME_W];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    assign valid_w[k] = count_r > CW'(k);
    if (k == 0) begin : g_head
      assign prev_gt_w[k] = 1'b1;
      tksit_cell u_cell (
        .clk          (clk),
        .cmd          (cmd),
        .valid_i      (valid_w[k]),
        .prev_gt_i    (prev_gt_w[k]),
        .prev_entry_i (cmd.cand),
        .entry_o      (entry_w[k]),
        .gt_o         (gt_w[k])
      );
    end else begin : g_body
      assign prev_gt_w[k] = gt_w[k-1];
      tksit_cell u_cell (
        .clk          (clk),
        .cmd          (cmd),
        .valid_i      (valid_w[k]),
        .prev_gt_i    (prev_gt_w[k]),
        .prev_entry_i (entry_w[k-1]),
        .entry_o      (entry_w[k]),
        .gt_o         (gt_w[k])
      );
    end
    assign place_w[k] = prev_gt_w[k] && !gt_w[k];
  end

  assign ins_ok = !gt_w[DEPTH-1];

  always_comb begin
    rank_c = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (place_w[k]) begin
        rank_c = rank_c | RANK_W'(k);
      end
    end
  end

  always_comb begin
    rd_entry = '0;
    rd_valid = 1'b0;
    for (int k = 0; k < RdSpan; k++) begin
      if (read_index == INDEX_W'(k) && valid_w[k]) begin
        rd_entry = entry_w[k];
        rd_valid = 1'b1;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_en && ins_ok && (count_r < CW'(DEPTH))) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[9:5] = COUNT_W'(count_nxt);
      if (mode == MODE_INSERT) begin
        out_data_nxt[0]   = ins_ok;
        out_data_nxt[4:1] = ins_ok ? rank_c : '0;
      end else begin
        out_data_nxt[10]      = rd_valid;
        out_data_nxt[41:11]   = rd_entry.score;
        out_data_nxt[49:42]   = rd_entry.level;
        out_data_nxt[81:50]   = rd_entry.timestamp;
        out_data_nxt[145:82]  = rd_entry.name_low;
        out_data_nxt[209:146] = rd_entry.name_high;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_place_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(place_w))
    else $error("more than one insert slot");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_en && ins_ok && (count_r < CW'(DEPTH)) |=> count_r == $past(count_r) + CW'(1))
    else $error("fill count did not advance on insert");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    !ins_ok |-> count_r == CW'(DEPTH))
    else $error("insert rejected while table not full");
`endif

endmodule
